@@ sv/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types for the clock page replacement core: controller states and
// the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cpr_pkg;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_FETCH = 5'b01000,
    S_PLACE = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic hand_fix;
    logic sweep;
    logic fetch;
    logic place;
    logic hit_done;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic use_at_hand;
  } status_t;

endpackage

@@ sv/cpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpr_ctrl
// Controller: sequences lookup scan, hand sweep, victim fetch and placement
// for one request at a time.
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cpr_pkg::status_t status_i,
  output cpr_pkg::cmd_t   cmd_o,
  output logic            busy_o
);
  import cpr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          cmd_o.hit_done = 1'b1;
          state_d        = S_IDLE;
        end else if (status_i.scan_end) begin
          cmd_o.hand_fix = 1'b1;
          state_d        = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (status_i.use_at_hand) begin
          cmd_o.sweep = 1'b1;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_PLACE;
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request accepted but controller not busy");

  a_place_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.place |-> $past(cmd_o.fetch))
    else $error("placement without victim fetch");

  a_sweep_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.hand_fix |-> !status_i.hit)
    else $error("sweep started on a hit");
`endif

endmodule

@@ sv/cpr_dpath.sv @@
// ----------------------------------------------------------------------------
// cpr_dpath
// Datapath: frame page memory, valid and use bits, clock hand, fault counter,
// frame count register and result registers.
// ----------------------------------------------------------------------------
module cpr_dpath #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  cpr_pkg::cmd_t        cmd_i,
  output cpr_pkg::status_t     status_o,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [3:0]           frame_slot_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [31:0]          fault_total_o
);
  import cpr_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  logic [4:0]           num_frames_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        scan_idx_q;
  logic [IW-1:0]        cmp_idx_q;
  logic                 cmp_vld_q;
  logic [IW-1:0]        hand_q, hand_next;
  logic [FRAMES-1:0]    valid_q, use_q;
  logic [31:0]          fault_q;
  logic [PAGE_BITS-1:0] mem_q [FRAMES];
  logic [PAGE_BITS-1:0] rdata_q;
  logic [IW-1:0]        rd_addr;
  logic                 issue;
  logic                 done_q, hit_q, ev_valid_q;
  logic [3:0]           slot_q;
  logic [PAGE_BITS-1:0] ev_page_q;

  always_comb begin
    int unsigned n;
    n = 32'(num_frames_q);
    if (n == 0) begin
      count_d = CW'(1);
    end else if (n > FRAMES) begin
      count_d = CW'(FRAMES);
    end else begin
      count_d = CW'(n);
    end
  end

  assign issue     = (scan_idx_q < count_q);
  assign rd_addr   = cmd_i.fetch ? hand_q : scan_idx_q[IW-1:0];
  assign hand_next = (CW'(hand_q) == count_q - CW'(1)) ? '0 : hand_q + IW'(1);

  assign status_o.hit         = cmp_vld_q && valid_q[cmp_idx_q] && (rdata_q == page_q);
  assign status_o.scan_end    = cmp_vld_q && (CW'(cmp_idx_q) == count_q - CW'(1));
  assign status_o.use_at_hand = use_q[hand_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      mem_q[hand_q] <= page_q;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q  <= page_i;
      count_q <= count_d;
    end
    if (cmd_i.hit_done) begin
      hit_q      <= 1'b1;
      slot_q     <= 4'(cmp_idx_q);
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
    end else if (cmd_i.place) begin
      hit_q      <= 1'b0;
      slot_q     <= 4'(hand_q);
      ev_valid_q <= valid_q[hand_q];
      ev_page_q  <= valid_q[hand_q] ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q <= 5'd16;
      scan_idx_q   <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      hand_q       <= '0;
      valid_q      <= '0;
      use_q        <= '0;
      fault_q      <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_frames_q <= cfg_wdata_i;
      end
      done_q <= cmd_i.hit_done || cmd_i.place;
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        cmp_vld_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        if (issue) begin
          scan_idx_q <= scan_idx_q + CW'(1);
          cmp_idx_q  <= scan_idx_q[IW-1:0];
          cmp_vld_q  <= 1'b1;
        end else begin
          cmp_vld_q <= 1'b0;
        end
      end
      if (cmd_i.hit_done) begin
        use_q[cmp_idx_q] <= 1'b1;
      end
      if (cmd_i.hand_fix && (CW'(hand_q) >= count_q)) begin
        hand_q <= '0;
      end
      if (cmd_i.sweep) begin
        use_q[hand_q] <= 1'b0;
        hand_q        <= hand_next;
      end
      if (cmd_i.place) begin
        valid_q[hand_q] <= 1'b1;
        use_q[hand_q]   <= 1'b1;
        hand_q          <= hand_next;
        if (fault_q != '1) begin
          fault_q <= fault_q + 32'd1;
        end
      end
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_slot_o    = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = fault_q;

`ifndef ASSERT_OFF
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.place || cmd_i.hit_done))
    else $error("result strobe without completion");

  a_fault_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |=> fault_q != '0)
    else $error("fault count zero after a fault");

  a_hand_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |=> CW'(hand_q) < count_q)
    else $error("clock hand beyond frames in use");
`endif

endmodule

@@ sv/clock_page_replacement_core.sv @@
// ----------------------------------------------------------------------------
// clock_page_replacement_core
// Second-chance (clock) page replacement over up to FRAMES page frames.
//
//   channel   handshake             payload
//   request   start_i / busy_o      page_i
//   result    done_o (one cycle)    hit_o, frame_slot_o, evicted_valid_o,
//                                   evicted_page_o, fault_total_o
//   config    cfg_we_i              cfg_wdata_i (num_frames)
//
// A hit ends the serial lookup of the frames in use over the frame memory's
// single read port; a miss then runs the one-frame-per-cycle hand sweep, the
// victim fetch and the placement. busy_o drops as done_o rises.
// Reset clears all frames to empty with clear use bits; no clearing pass.
// Results cannot be stalled; done_o is high for one cycle per request.
// ----------------------------------------------------------------------------
module clock_page_replacement_core #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [PAGE_BITS-1:0] page_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [3:0]           frame_slot_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [31:0]          fault_total_o
);
  import cpr_pkg::*;

  cmd_t    cmd;
  status_t status;

  cpr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  cpr_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .page_i          (page_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

endmodule
